/* sv/bfc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bfc_pkg;

   localparam int COORD_BITS_DEF     = 36;
   localparam int ANGLE_DECIMALS_DEF = 4;
   localparam int CORDIC_STAGES_DEF  = 26;

   localparam int FRAC_BITS  = 60;
   localparam int WORD_BITS  = 64;
   localparam int OUT_BITS   = 22;
   localparam int NORM_STEPS = 6;   // 32,16,8,4,2,1 over a 60-bit word

   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_neg;
      logic dy_pos;
   } side_type;

   // arctan(1/5) in Q60, Taylor series with floor terms
   function automatic logic [63:0] atan_inv5();
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] t;
      p = (64'd1 << FRAC_BITS) / 64'd5;
      s = '0;
      for (int k = 0; k < 40; k++) begin
         if (p != 0) begin
            t = p / 64'(2 * k + 1);
            if (k % 2 == 0) s = s + t; else s = s - t;
            p = p / 64'd25;
         end
      end
      return s;
   endfunction

   function automatic logic [63:0] atan_inv239();
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] t;
      p = (64'd1 << FRAC_BITS) / 64'd239;
      s = '0;
      for (int k = 0; k < 40; k++) begin
         if (p != 0) begin
            t = p / 64'(2 * k + 1);
            if (k % 2 == 0) s = s + t; else s = s - t;
            p = p / 64'd57121;
         end
      end
      return s;
   endfunction

   localparam logic [63:0] QUARTER_PI = 64'd4 * atan_inv5() - atan_inv239();

   // arctan(2^-i) in Q60, i >= 1
   function automatic logic [63:0] atan_pow2(input int i);
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] t;
      p = 64'd1 << (FRAC_BITS - i);
      s = '0;
      for (int k = 0; k < 64; k++) begin
         if (p != 0) begin
            t = p / 64'(2 * k + 1);
            if (k % 2 == 0) s = s + t; else s = s - t;
            p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
         end
      end
      return s;
   endfunction

   function automatic logic [63:0] atan_entry(input int i);
      return (i == 0) ? QUARTER_PI : atan_pow2(i);
   endfunction

endpackage

`default_nettype wire

/* sv/bfc_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bfc_req_if #(
   parameter int COORD_BITS = bfc_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] station_x;
   logic signed [COORD_BITS-1:0] station_y;
   logic signed [COORD_BITS-1:0] target_x;
   logic signed [COORD_BITS-1:0] target_y;

   modport source (output valid, station_x, station_y, target_x, target_y, input ready);
   modport sink (input valid, station_x, station_y, target_x, target_y, output ready);
endinterface

interface bfc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfc_pkg::OUT_BITS-1:0]  bearing;

   modport source (output valid, bearing, input ready);
   modport sink (input valid, bearing, output ready);
endinterface

`default_nettype wire

/* sv/bearing_from_coordinates.sv */
// Each request passes the difference, absolute-value, normalisation, CORDIC, clamp and
// decimal-digit stages and then the output register.
// Throughput: one request per cycle; every stage holds its item on a stall and a
// stage with no item takes a new one, so bubbles are squeezed out.
// Reset (synchronous) clears all stage valid bits and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module bearing_from_coordinates #(
   parameter int COORD_BITS     = bfc_pkg::COORD_BITS_DEF,
   parameter int ANGLE_DECIMALS = bfc_pkg::ANGLE_DECIMALS_DEF,
   parameter int CORDIC_STAGES  = bfc_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bfc_req_if.sink    req_ch,
   bfc_rsp_if.source  rsp_ch
);

   localparam int DIGITS  = ANGLE_DECIMALS + 2;
   localparam int G_W     = $clog2(2 * 10**DIGITS);
   localparam int S_ABS   = 1;
   localparam int S_NORM  = 2;
   localparam int S_CORD  = S_NORM + bfc_pkg::NORM_STEPS;
   localparam int S_CLAMP = S_CORD + CORDIC_STAGES;
   localparam int S_DIG   = S_CLAMP + 1;
   localparam int N_ST    = S_DIG + 5 * DIGITS;

   localparam logic [31:0] SCALE  = 32'(10**ANGLE_DECIMALS);
   localparam logic [31:0] A_MAX  = 32'(100 * 10**ANGLE_DECIMALS);
   localparam logic [31:0] B_100  = 32'(100 * 10**ANGLE_DECIMALS);
   localparam logic [31:0] B_200  = 32'(200 * 10**ANGLE_DECIMALS);
   localparam logic [31:0] B_300  = 32'(300 * 10**ANGLE_DECIMALS);
   localparam logic [31:0] B_400  = 32'(400 * 10**ANGLE_DECIMALS);

   typedef struct packed {
      bfc_pkg::side_type side;
      logic [63:0]       x;
      logic [63:0]       y;
      logic [63:0]       z;   // angle, then division remainder
      logic [G_W-1:0]    g;   // quotient digits
   } stage_type;

   stage_type st_ff [N_ST];
   stage_type st_in [N_ST];
   logic [N_ST-1:0] vld_ff;
   logic [N_ST:0]   ce;

   logic                        out_vld_ff;
   logic [bfc_pkg::OUT_BITS-1:0] bearing_ff;
   logic [bfc_pkg::OUT_BITS-1:0] bearing_in;

   assign ce[N_ST] = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready = ce[0];

   genvar s;
   generate
      for (s = 0; s < N_ST; s++) begin : g_st
         assign ce[s] = !vld_ff[s] || ce[s+1];

         if (s == 0) begin : g_diff
            always_comb begin
               st_in[s]   = '0;
               st_in[s].x = 64'($signed(req_ch.target_x[COORD_BITS-1:0]))
                          - 64'($signed(req_ch.station_x[COORD_BITS-1:0]));
               st_in[s].y = 64'($signed(req_ch.target_y[COORD_BITS-1:0]))
                          - 64'($signed(req_ch.station_y[COORD_BITS-1:0]));
            end
         end else if (s == S_ABS) begin : g_abs
            always_comb begin
               st_in[s]              = st_ff[s-1];
               st_in[s].side.dx_zero = (st_ff[s-1].x == '0);
               st_in[s].side.dx_neg  = st_ff[s-1].x[63];
               st_in[s].side.dy_neg  = st_ff[s-1].y[63];
               st_in[s].side.dy_pos  = !st_ff[s-1].y[63] && (st_ff[s-1].y != '0);
               st_in[s].x = st_ff[s-1].x[63] ? -st_ff[s-1].x : st_ff[s-1].x;
               st_in[s].y = st_ff[s-1].y[63] ? -st_ff[s-1].y : st_ff[s-1].y;
            end
         end else if (s < S_CORD) begin : g_norm
            localparam int SH = 32 >> (s - S_NORM);
            always_comb begin
               st_in[s] = st_ff[s-1];
               // leading-zero normalisation of the larger magnitude to bit 59
               if (((st_ff[s-1].x | st_ff[s-1].y) >> (bfc_pkg::FRAC_BITS - SH)) == '0) begin
                  st_in[s].x = st_ff[s-1].x << SH;
                  st_in[s].y = st_ff[s-1].y << SH;
               end
            end
         end else if (s < S_CLAMP) begin : g_cordic
            localparam int I = s - S_CORD;
            localparam logic [63:0] ANG = bfc_pkg::atan_entry(I);
            logic [63:0] xs;
            logic [63:0] ys;
            always_comb begin
               xs = 64'($signed(st_ff[s-1].x) >>> I);
               ys = 64'($signed(st_ff[s-1].y) >>> I);
               st_in[s] = st_ff[s-1];
               if (!st_ff[s-1].y[63]) begin
                  st_in[s].x = st_ff[s-1].x + ys;
                  st_in[s].y = st_ff[s-1].y - xs;
                  st_in[s].z = st_ff[s-1].z + ANG;
               end else begin
                  st_in[s].x = st_ff[s-1].x - ys;
                  st_in[s].y = st_ff[s-1].y + xs;
                  st_in[s].z = st_ff[s-1].z - ANG;
               end
            end
         end else if (s == S_CLAMP) begin : g_clamp
            logic [63:0] uz;
            always_comb begin
               uz = st_ff[s-1].z[63] ? 64'd0 : st_ff[s-1].z;
               st_in[s] = st_ff[s-1];
               if (uz >= bfc_pkg::QUARTER_PI) begin
                  st_in[s].z = uz - bfc_pkg::QUARTER_PI;
                  st_in[s].g = G_W'(1);
               end else begin
                  st_in[s].z = uz;
                  st_in[s].g = '0;
               end
            end
         end else if (((s - S_DIG) % 5) == 0) begin : g_x10
            always_comb begin
               st_in[s]   = st_ff[s-1];
               st_in[s].z = (st_ff[s-1].z << 3) + (st_ff[s-1].z << 1);
               st_in[s].g = (st_ff[s-1].g << 3) + (st_ff[s-1].g << 1);
            end
         end else begin : g_digit
            // one quotient bit of the decimal digit per stage: 8, 4, 2, 1
            localparam int C = 8 >> (((s - S_DIG) % 5) - 1);
            localparam logic [63:0] CP = 64'(C) * bfc_pkg::QUARTER_PI;
            always_comb begin
               st_in[s] = st_ff[s-1];
               if (st_ff[s-1].z >= CP) begin
                  st_in[s].z = st_ff[s-1].z - CP;
                  st_in[s].g = st_ff[s-1].g + G_W'(C);
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (ce[s]) begin
               vld_ff[s] <= (s == 0) ? req_ch.valid : vld_ff[(s == 0) ? 0 : s-1];
            end
            if (ce[s]) begin
               st_ff[s] <= st_in[s];
            end
         end
      end
   endgenerate

   logic [31:0] g32;
   logic [31:0] alpha;
   logic [31:0] res;

   always_comb begin
      g32   = 32'(st_ff[N_ST-1].g);
      alpha = (g32 + 32'd1) >> 1;
      if (alpha > A_MAX) alpha = A_MAX;
      if (st_ff[N_ST-1].side.dx_zero) begin
         res = st_ff[N_ST-1].side.dy_pos ? B_100 : B_300;
      end else if (!st_ff[N_ST-1].side.dx_neg) begin
         res = st_ff[N_ST-1].side.dy_neg ? B_400 - alpha : alpha;
      end else begin
         res = st_ff[N_ST-1].side.dy_neg ? B_200 + alpha : B_200 - alpha;
      end
      bearing_in = res[bfc_pkg::OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (ce[N_ST]) begin
         out_vld_ff <= vld_ff[N_ST-1];
      end
      if (ce[N_ST]) begin
         bearing_ff <= bearing_in;
      end
   end

   assign rsp_ch.valid   = out_vld_ff;
   assign rsp_ch.bearing = bearing_ff;

   // division remainder always ends below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[N_ST-1] |-> (st_ff[N_ST-1].z < bfc_pkg::QUARTER_PI))
      else $error("remainder out of range");

   // a stalled last stage keeps its request
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[N_ST-1] && !ce[N_ST-1]) |=> vld_ff[N_ST-1])
      else $error("request lost on stall");

   // bearing stays within one circle, checked where it fits the output
   generate
      if (B_400 < (32'd1 << bfc_pkg::OUT_BITS) && SCALE != 32'd0) begin : g_range_chk
         a_range: assert property (@(posedge clock) disable iff (reset)
            rsp_ch.valid |-> (32'(rsp_ch.bearing) <= B_400))
            else $error("bearing beyond full circle");
      end
   endgenerate

endmodule

`default_nettype wire
